// ===== hw/rtl/dlp_pkg.sv =====
`default_nettype none

package dlp_pkg;

    localparam int BYTE_W = 8;
    localparam int VALUE_W = 31;
    localparam int DIGIT_W = 4;
    localparam int PROD_W = VALUE_W + DIGIT_W;

    localparam int LINE_LIMIT_DEFAULT = 10;

    localparam logic [BYTE_W-1:0] BLANK_MAX = 8'd32;
    localparam logic [BYTE_W-1:0] DIGIT_LO = 8'd48;
    localparam logic [BYTE_W-1:0] DIGIT_HI = 8'd57;
    localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

    localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = {VALUE_W{1'b1}};

    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_PARSE = 2'd1,
        STATUS_READ = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_DIGITS = 2'd1,
        PH_TRAIL = 2'd2
    } phase_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dlp_if.sv =====
`default_nettype none

// Byte channel into the parser.
interface dlp_byte_if;
    logic                         valid;
    logic                         ready;
    logic [dlp_pkg::BYTE_W-1:0]   char_byte;
    logic                         end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

// Result channel out of the parser.
interface dlp_result_if;
    logic                         valid;
    logic                         ready;
    logic [dlp_pkg::VALUE_W-1:0]  value;
    dlp_pkg::status_t             status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

// Write channel for the max_value register.
interface dlp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dlp_pkg::VALUE_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/decimal_line_parser_unit.sv =====
`default_nettype none

// Decimal line parser. Bytes enter on byte_in one item per cycle unless a result held
// on result_out stalls the input; each line ending in a newline (byte 10) yields one item
// on result_out: the unsigned decimal value with status ok, or value 0 with parse error
// when the line has no digit, holds a stray character, runs past LINE_LIMIT bytes, or
// grows beyond max_value. Blanks are bytes of value 32 or less and may lead or trail the
// digits. An end_of_input item yields read error and clears the line. Other bytes yield
// nothing. Throughput is one item per cycle while result_out is ready. A byte is loaded
// into the input register when accepted, and its result into the result register when
// the input stage moves on, which waits while a result is held on result_out.
// The line-state update holds the longest path: the multiply-by-ten-and-add of the
// accumulator and its compare against max_value.
// max_value is written over cfg (always ready) and should only change while no line is
// in progress.
module decimal_line_parser_unit #(
    parameter int LINE_LIMIT = dlp_pkg::LINE_LIMIT_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dlp_byte_if.sink     byte_in,
    dlp_result_if.source result_out,
    dlp_cfg_if.sink      cfg
);
    import dlp_pkg::*;

    localparam int CNT_W = $clog2(LINE_LIMIT + 1);
    localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(LINE_LIMIT);

    // Configuration register
    logic [VALUE_W-1:0] max_value_reg;

    // Input register
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic               eoi_reg;

    // Line state
    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               err_reg, err_next;
    logic               seen_reg, seen_next;

    // Result register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    status_t            out_status_reg, out_status_next;
    logic               emit;

    logic               advance;
    logic               proc;
    logic               in_accept;
    logic               is_blank;
    logic               is_digit;
    logic [PROD_W-1:0]  prod;
    logic               fits;

    // The result slot is free, or drains this cycle: the input stage may move on.
    assign advance = !out_valid_reg || result_out.ready;
    assign proc = in_valid_reg && advance;
    assign byte_in.ready = !in_valid_reg || advance;
    assign in_accept = byte_in.valid && byte_in.ready;
    assign cfg.ready = 1'b1;

    assign result_out.valid = out_valid_reg;
    assign result_out.value = out_value_reg;
    assign result_out.status = out_status_reg;

    assign is_blank = byte_reg <= BLANK_MAX;
    assign is_digit = (byte_reg >= DIGIT_LO) && (byte_reg <= DIGIT_HI);

    // acc * 10 + digit as two shifted copies plus the digit; digit codes carry the value
    // in their low nibble.
    assign prod = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                + {{(PROD_W-DIGIT_W){1'b0}}, byte_reg[DIGIT_W-1:0]};
    assign fits = prod <= {{DIGIT_W{1'b0}}, max_value_reg};

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        acc_next = acc_reg;
        err_next = err_reg;
        seen_next = seen_reg;
        emit = 1'b0;
        out_value_next = '0;
        out_status_next = STATUS_READ;

        if (proc)
        begin
            if (eoi_reg || byte_reg == NEWLINE)
            begin
                emit = 1'b1;
                if (eoi_reg)
                begin
                    out_status_next = STATUS_READ;
                end
                else if (err_reg || !seen_reg)
                begin
                    out_status_next = STATUS_PARSE;
                end
                else
                begin
                    out_status_next = STATUS_OK;
                    out_value_next = acc_reg;
                end
                // Start the next line from scratch.
                phase_next = PH_LEAD;
                count_next = '0;
                acc_next = '0;
                err_next = 1'b0;
                seen_next = 1'b0;
            end
            else if (count_reg >= LIMIT_CNT)
            begin
                // Line too long: flag and drop the byte.
                err_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                if (!err_reg)
                begin
                    unique case (phase_reg)
                        PH_LEAD:
                        begin
                            if (is_digit)
                            begin
                                seen_next = 1'b1;
                                phase_next = PH_DIGITS;
                                if (fits)
                                    acc_next = prod[VALUE_W-1:0];
                                else
                                    err_next = 1'b1;
                            end
                            else if (!is_blank)
                            begin
                                err_next = 1'b1;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                seen_next = 1'b1;
                                if (fits)
                                    acc_next = prod[VALUE_W-1:0];
                                else
                                    err_next = 1'b1;
                            end
                            else if (is_blank)
                            begin
                                phase_next = PH_TRAIL;
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (!is_blank)
                                err_next = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= MAX_VALUE_RESET;
            in_valid_reg <= 1'b0;
            phase_reg <= PH_LEAD;
            count_reg <= '0;
            acc_reg <= '0;
            err_reg <= 1'b0;
            seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                max_value_reg <= cfg.data;

            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (proc)
                in_valid_reg <= 1'b0;

            phase_reg <= phase_next;
            count_reg <= count_next;
            acc_reg <= acc_next;
            err_reg <= err_next;
            seen_reg <= seen_next;

            if (proc && emit)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: load only, no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= byte_in.char_byte;
            eoi_reg <= byte_in.end_of_input;
        end
        if (proc && emit)
        begin
            out_value_reg <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    a_eoi_reads: assert property (@(posedge clk) disable iff (!rst_n)
        proc && eoi_reg |=> out_valid_reg && out_status_reg == STATUS_READ)
        else $error("end of input did not give read error");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != STATUS_OK |-> out_value_reg == '0)
        else $error("error result carries a nonzero value");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LIMIT_CNT)
        else $error("line count ran past the limit");

    a_lead_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LEAD |-> acc_reg == '0 && !seen_reg)
        else $error("leading phase holds digit state");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_in.ready |-> in_valid_reg && out_valid_reg && !result_out.ready)
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
